FILE: sv/ecd_pkg.sv
// Package for the epoch-millisecond to civil date/time converter.
// Holds field widths, calendar constants, stage payload types and table functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

    localparam int unsigned DIV_STEPS_DEF = 4;

    localparam int unsigned MS_W   = 54;
    localparam logic signed [MS_W-1:0] TIME_MAX = 54'sd8640000000000000;
    localparam logic signed [MS_W-1:0] TIME_MIN = -54'sd8640000000000000;
    // 100065428 days in ms; makes every in-range count non-negative and
    // lines the day count up with a whole number of 400-year eras
    localparam logic [MS_W:0] MS_OFFSET = 55'd8645652979200000;

    localparam int unsigned MS_LO_W    = 10;
    localparam int unsigned DAY_DIV_HI = 84375;
    localparam int unsigned DAYS_W     = 28;
    localparam int unsigned TOD_W      = 27;

    localparam int unsigned ERA_DAYS   = 146097;
    localparam int unsigned ERA_W      = 11;
    localparam int unsigned DOE_W      = 18;
    localparam int unsigned CENT_DAYS  = 36524;
    localparam int unsigned ERA_LAST   = 146096;
    localparam int unsigned QUAD_DAYS  = 1460;
    localparam int unsigned QUAD_W     = 7;
    localparam int unsigned YEAR_DAYS  = 365;
    localparam int unsigned YOE_W      = 9;
    localparam int unsigned DOY_W      = 9;
    localparam int unsigned MP_W       = 4;
    localparam int unsigned YEAR_BIAS  = 272000;

    localparam int unsigned MS_PER_HOUR = 3600000;
    localparam int unsigned MS_PER_MIN  = 60000;
    localparam int unsigned MS_PER_SEC  = 1000;

    localparam int unsigned YEAR_W = 20;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned DAY_W  = 5;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned SEC_W  = 6;
    localparam int unsigned MSEC_W = 10;
    localparam int unsigned WDAY_W = 3;
    localparam int unsigned YDAY_W = 9;

    typedef struct packed {
        logic [MS_LO_W-1:0] ms_lo;
        logic               range_err;
    } a_side_t;

    typedef struct packed {
        logic [TOD_W-1:0] tod;
        logic             range_err;
    } b_side_t;

    typedef struct packed {
        logic [ERA_W-1:0] era_idx;
        logic [DOE_W-1:0] doe;
        logic [TOD_W-1:0] tod;
        logic             range_err;
    } c_side_t;

    typedef struct packed {
        logic [ERA_W-1:0]  era_idx;
        logic [DOE_W-1:0]  doe;
        logic [WDAY_W-1:0] weekday;
        logic [TOD_W-1:0]  tod;
        logic              range_err;
    } d_side_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [WDAY_W-1:0] weekday;
        logic [YDAY_W-1:0] yday;
        logic              range_err;
    } date_t;

    typedef struct packed {
        date_t            date;
        logic [TOD_W-1:0] tod;
    } cal_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        date_t             date;
    } hr_side_t;

    typedef struct packed {
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        date_t             date;
    } min_side_t;

    // (doe + 3) mod 7; octal digits fold since 8 is 1 mod 7
    function automatic logic [WDAY_W-1:0] weekday_of(input logic [DOE_W-1:0] doe);
        logic [20:0] x;
        logic [5:0]  s;
        logic [3:0]  f;
        logic [3:0]  r;
        x = 21'(doe) + 21'd3;
        s = 6'd0;
        for (int k = 0; k < 7; k++) begin
            s = s + {3'b000, x[3*k +: 3]};
        end
        f = {1'b0, s[5:3]} + {1'b0, s[2:0]};
        if (f >= 4'd14) begin
            r = f - 4'd14;
        end else if (f >= 4'd7) begin
            r = f - 4'd7;
        end else begin
            r = f;
        end
        return r[WDAY_W-1:0];
    endfunction

    // first day of each month, counted from March 1
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // days before the month, counted from January 1
    function automatic logic [YDAY_W-1:0] cum_days(input logic leap,
                                                   input logic [MON_W-1:0] idx);
        logic [YDAY_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        if (leap && (idx >= 4'd2) && (idx <= 4'd11)) begin
            v = v + 9'd1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ecd_cdiv.sv
// Pipelined restoring divider by a constant, with a side payload carried along.
// A few quotient bits per register stage; each stage has its own valid and stall.
// Depends on ecd_pkg for the default step count.
`timescale 1ns / 1ps
`default_nettype none

module ecd_cdiv
    import ecd_pkg::*;
#(
    parameter int unsigned DIVISOR = 3,
    parameter int unsigned QW      = 2,
    parameter int unsigned SW      = 1,
    parameter int unsigned STEPS   = DIV_STEPS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [$clog2(DIVISOR)+QW-1:0] in_dividend,
    input  wire  [SW-1:0]                 in_side,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [QW-1:0]                 out_quot,
    output logic [$clog2(DIVISOR)-1:0]    out_rem,
    output logic [SW-1:0]                 out_side
);

    localparam int unsigned VW = $clog2(DIVISOR);
    localparam int unsigned AW = VW + QW;
    localparam int unsigned NS = (QW + STEPS - 1) / STEPS;
    localparam logic [VW:0] DIV_C = (VW + 1)'(DIVISOR);

    function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc);
        logic [VW:0]   trial;
        logic [VW:0]   diff;
        logic [AW-1:0] res;
        trial = {acc[AW-1:QW], acc[QW-1]};
        diff  = trial - DIV_C;
        if (trial >= DIV_C) begin
            res = {diff[VW-1:0], acc[QW-2:0], 1'b1};
        end else begin
            res = {trial[VW-1:0], acc[QW-2:0], 1'b0};
        end
        return res;
    endfunction

    logic          v_reg    [NS];
    logic [AW-1:0] acc_reg  [NS];
    logic [SW-1:0] side_reg [NS];

    logic          stg_v    [NS+1];
    logic [AW-1:0] stg_acc  [NS+1];
    logic [SW-1:0] stg_side [NS+1];
    logic          rdy      [NS+1];

    assign stg_v[0]    = in_valid;
    assign stg_acc[0]  = in_dividend;
    assign stg_side[0] = in_side;
    assign rdy[NS]     = out_ready;

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic [AW-1:0] acc_next;

        always_comb begin
            acc_next = stg_acc[i];
            for (int k = 0; k < STEPS; k++) begin
                if (i * STEPS + k < QW) begin
                    acc_next = div_step(acc_next);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                v_reg[i] <= stg_v[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i] && stg_v[i]) begin
                acc_reg[i]  <= acc_next;
                side_reg[i] <= stg_side[i];
            end
        end

        assign rdy[i]        = !v_reg[i] || rdy[i+1];
        assign stg_v[i+1]    = v_reg[i];
        assign stg_acc[i+1]  = acc_reg[i];
        assign stg_side[i+1] = side_reg[i];
    end

    assign in_ready  = rdy[0];
    assign out_valid = stg_v[NS];
    assign out_quot  = stg_acc[NS][QW-1:0];
    assign out_rem   = stg_acc[NS][AW-1:QW];
    assign out_side  = stg_side[NS];

endmodule

`default_nettype wire

FILE: sv/ecd_cal.sv
// Calendar stages: day of era and year of era to year, month, day and day of year.
// Four register stages with per-stage valid and stall; zeroes the date on a range error.
// Depends on ecd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecd_cal
    import ecd_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire  [YOE_W-1:0]  in_yoe,
    input  var   d_side_t     in_side,
    output logic              out_valid,
    input  wire               out_ready,
    output cal_t              out_cal
);

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

    assign s4_rdy   = !s4_v_reg || out_ready;
    assign s3_rdy   = !s3_v_reg || s4_rdy;
    assign s2_rdy   = !s2_v_reg || s3_rdy;
    assign s1_rdy   = !s1_v_reg || s2_rdy;
    assign in_ready = s1_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else begin
            if (s1_rdy) begin
                s1_v_reg <= in_valid;
            end
            if (s2_rdy) begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_rdy) begin
                s3_v_reg <= s2_v_reg;
            end
            if (s4_rdy) begin
                s4_v_reg <= s3_v_reg;
            end
        end
    end

    // stage 1: day of the March-based year
    logic [DOY_W-1:0]  s1_doy_reg, s1_doy_next;
    logic [YOE_W-1:0]  s1_yoe_reg;
    logic [ERA_W-1:0]  s1_era_reg;
    logic [WDAY_W-1:0] s1_wday_reg;
    logic [TOD_W-1:0]  s1_tod_reg;
    logic              s1_err_reg;
    logic [DOE_W-1:0]  yoe_days;
    logic [DOE_W-1:0]  doe_diff;
    logic [1:0]        yoe_cent;

    always_comb begin
        yoe_cent = {1'b0, in_yoe >= YOE_W'(100)} + {1'b0, in_yoe >= YOE_W'(200)}
                 + {1'b0, in_yoe >= YOE_W'(300)};
        yoe_days = DOE_W'(in_yoe) * DOE_W'(YEAR_DAYS)
                 + DOE_W'(in_yoe[YOE_W-1:2])
                 - DOE_W'(yoe_cent)
                 + DOE_W'(in_yoe >= YOE_W'(400));
        doe_diff = in_side.doe - yoe_days;
        s1_doy_next = doe_diff[DOY_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy && in_valid) begin
            s1_doy_reg  <= s1_doy_next;
            s1_yoe_reg  <= in_yoe;
            s1_era_reg  <= in_side.era_idx;
            s1_wday_reg <= in_side.weekday;
            s1_tod_reg  <= in_side.tod;
            s1_err_reg  <= in_side.range_err;
        end
    end

    // stage 2: March-based month by search over month starts
    logic [MP_W-1:0]   s2_mp_reg, s2_mp_next;
    logic [DOY_W-1:0]  s2_doy_reg;
    logic [YOE_W-1:0]  s2_yoe_reg;
    logic [ERA_W-1:0]  s2_era_reg;
    logic [WDAY_W-1:0] s2_wday_reg;
    logic [TOD_W-1:0]  s2_tod_reg;
    logic              s2_err_reg;

    always_comb begin
        s2_mp_next = '0;
        for (int k = 1; k < 12; k++) begin
            s2_mp_next = s2_mp_next + MP_W'(s1_doy_reg >= month_start(MP_W'(k)));
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_rdy && s1_v_reg) begin
            s2_mp_reg   <= s2_mp_next;
            s2_doy_reg  <= s1_doy_reg;
            s2_yoe_reg  <= s1_yoe_reg;
            s2_era_reg  <= s1_era_reg;
            s2_wday_reg <= s1_wday_reg;
            s2_tod_reg  <= s1_tod_reg;
            s2_err_reg  <= s1_err_reg;
        end
    end

    // stage 3: month, day, year and leap flag
    logic [YEAR_W-1:0] s3_year_reg, s3_year_next;
    logic [MON_W-1:0]  s3_mon_reg, s3_mon_next;
    logic [DAY_W-1:0]  s3_dom_reg, s3_dom_next;
    logic              s3_leap_reg, s3_leap_next;
    logic [WDAY_W-1:0] s3_wday_reg;
    logic [TOD_W-1:0]  s3_tod_reg;
    logic              s3_err_reg;
    logic [DOY_W-1:0]  dom_full;
    logic [YOE_W-1:0]  y4;
    logic              jan_feb;

    always_comb begin
        dom_full    = s2_doy_reg - month_start(s2_mp_reg) + DOY_W'(1);
        s3_dom_next = dom_full[DAY_W-1:0];
        jan_feb     = (s2_mp_reg >= MP_W'(10));
        if (jan_feb) begin
            s3_mon_next = s2_mp_reg - MON_W'(9);
        end else begin
            s3_mon_next = s2_mp_reg + MON_W'(3);
        end
        y4 = s2_yoe_reg + YOE_W'(jan_feb);
        s3_year_next = YEAR_W'(s2_era_reg) * YEAR_W'(400) + YEAR_W'(y4)
                     - YEAR_W'(YEAR_BIAS);
        s3_leap_next = (y4[1:0] == 2'b00) && (y4 != YOE_W'(100))
                    && (y4 != YOE_W'(200)) && (y4 != YOE_W'(300));
    end

    always_ff @(posedge aclk) begin
        if (s3_rdy && s2_v_reg) begin
            s3_year_reg <= s3_year_next;
            s3_mon_reg  <= s3_mon_next;
            s3_dom_reg  <= s3_dom_next;
            s3_leap_reg <= s3_leap_next;
            s3_wday_reg <= s2_wday_reg;
            s3_tod_reg  <= s2_tod_reg;
            s3_err_reg  <= s2_err_reg;
        end
    end

    // stage 4: day of year; drop the date on a range error
    cal_t s4_cal_reg, s4_cal_next;

    always_comb begin
        s4_cal_next = '0;
        s4_cal_next.tod = s3_tod_reg;
        s4_cal_next.date.range_err = s3_err_reg;
        if (!s3_err_reg) begin
            s4_cal_next.date.year    = s3_year_reg;
            s4_cal_next.date.month   = s3_mon_reg;
            s4_cal_next.date.day     = s3_dom_reg;
            s4_cal_next.date.weekday = s3_wday_reg;
            s4_cal_next.date.yday    = cum_days(s3_leap_reg, s3_mon_reg - MON_W'(1))
                                     + YDAY_W'(s3_dom_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_rdy && s3_v_reg) begin
            s4_cal_reg <= s4_cal_next;
        end
    end

    assign out_valid = s4_v_reg;
    assign out_cal   = s4_cal_reg;

endmodule

`default_nettype wire

FILE: sv/epoch_ms_to_civil_date_time.sv
// Epoch milliseconds to proleptic Gregorian UTC date and time, fully pipelined.
// Throughput: one word per cycle while m_ready is high; every stage stalls on
// its own, and bubbles fill in.
// Reset (aresetn low, synchronous) clears all valid bits; no other state is kept.
// Depends on ecd_pkg, ecd_cdiv and ecd_cal.
`timescale 1ns / 1ps
`default_nettype none

module epoch_ms_to_civil_date_time
    import ecd_pkg::*;
#(
    parameter int unsigned DIV_STEPS = DIV_STEPS_DEF
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire  signed [MS_W-1:0]    s_epoch_ms,
    output logic                      m_valid,
    input  wire                       m_ready,
    output logic signed [YEAR_W-1:0]  m_year,
    output logic [MON_W-1:0]          m_month,
    output logic [DAY_W-1:0]          m_day,
    output logic [HOUR_W-1:0]         m_hour,
    output logic [MIN_W-1:0]          m_minute,
    output logic [SEC_W-1:0]          m_second,
    output logic [MSEC_W-1:0]         m_millisecond,
    output logic [WDAY_W-1:0]         m_weekday,
    output logic [YDAY_W-1:0]         m_day_of_year,
    output logic                      m_range_error
);

    // front stage: range check and offset into a non-negative count
    logic            f_v_reg;
    logic [MS_W-1:0] f_u_reg, f_u_next;
    logic            f_err_reg, f_err_next;
    logic [MS_W:0]   u_sum;
    logic            f_rdy;
    logic            a_in_ready;

    always_comb begin
        u_sum      = {s_epoch_ms[MS_W-1], s_epoch_ms} + MS_OFFSET;
        f_u_next   = u_sum[MS_W-1:0];
        f_err_next = (s_epoch_ms < TIME_MIN) || (s_epoch_ms > TIME_MAX);
    end

    assign f_rdy   = !f_v_reg || a_in_ready;
    assign s_ready = f_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (f_rdy) begin
            f_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_rdy && s_valid) begin
            f_u_reg   <= f_u_next;
            f_err_reg <= f_err_next;
        end
    end

    // days and time of day: divide by 1024 * 84375
    a_side_t               a_side_in, a_side_out;
    logic                  a_out_valid, b_in_ready;
    logic [DAYS_W-1:0]     a_quot;
    logic [TOD_W-MS_LO_W-1:0] a_rem;

    assign a_side_in.ms_lo     = f_u_reg[MS_LO_W-1:0];
    assign a_side_in.range_err = f_err_reg;

    ecd_cdiv #(
        .DIVISOR (DAY_DIV_HI),
        .QW      (DAYS_W),
        .SW      ($bits(a_side_t)),
        .STEPS   (DIV_STEPS)
    ) u_div_day (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (f_v_reg),
        .in_ready    (a_in_ready),
        .in_dividend ({1'b0, f_u_reg[MS_W-1:MS_LO_W]}),
        .in_side     (a_side_in),
        .out_valid   (a_out_valid),
        .out_ready   (b_in_ready),
        .out_quot    (a_quot),
        .out_rem     (a_rem),
        .out_side    (a_side_out)
    );

    // era and day of era
    b_side_t          b_side_in, b_side_out;
    logic             b_out_valid, c_in_ready;
    logic [ERA_W-1:0] b_quot;
    logic [DOE_W-1:0] b_rem;

    assign b_side_in.tod       = a_side_out.range_err ? '0 : {a_rem, a_side_out.ms_lo};
    assign b_side_in.range_err = a_side_out.range_err;

    ecd_cdiv #(
        .DIVISOR (ERA_DAYS),
        .QW      (ERA_W),
        .SW      ($bits(b_side_t)),
        .STEPS   (DIV_STEPS)
    ) u_div_era (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (a_out_valid),
        .in_ready    (b_in_ready),
        .in_dividend ({1'b0, a_quot}),
        .in_side     (b_side_in),
        .out_valid   (b_out_valid),
        .out_ready   (c_in_ready),
        .out_quot    (b_quot),
        .out_rem     (b_rem),
        .out_side    (b_side_out)
    );

    // four-year groups within the era
    c_side_t           c_side_in, c_side_out;
    logic              c_out_valid, g_rdy;
    logic [QUAD_W-1:0] c_quot;

    assign c_side_in.era_idx   = b_quot;
    assign c_side_in.doe       = b_rem;
    assign c_side_in.tod       = b_side_out.tod;
    assign c_side_in.range_err = b_side_out.range_err;

    ecd_cdiv #(
        .DIVISOR (QUAD_DAYS),
        .QW      (QUAD_W),
        .SW      ($bits(c_side_t)),
        .STEPS   (DIV_STEPS)
    ) u_div_quad (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (b_out_valid),
        .in_ready    (c_in_ready),
        .in_dividend (b_rem),
        .in_side     (c_side_in),
        .out_valid   (c_out_valid),
        .out_ready   (g_rdy),
        .out_quot    (c_quot),
        .out_rem     (),
        .out_side    (c_side_out)
    );

    // numerator for year of era, and weekday
    logic             g_v_reg;
    logic [DOE_W-1:0] g_num_reg, g_num_next;
    d_side_t          g_side_reg, g_side_next;
    logic [2:0]       cent_cnt;
    logic             d_in_ready;

    always_comb begin
        cent_cnt = {2'b00, c_side_out.doe >= DOE_W'(CENT_DAYS)}
                 + {2'b00, c_side_out.doe >= DOE_W'(2 * CENT_DAYS)}
                 + {2'b00, c_side_out.doe >= DOE_W'(3 * CENT_DAYS)}
                 + {2'b00, c_side_out.doe >= DOE_W'(ERA_LAST)};
        g_num_next = c_side_out.doe - DOE_W'(c_quot) + DOE_W'(cent_cnt)
                   - DOE_W'(c_side_out.doe >= DOE_W'(ERA_LAST));
        g_side_next.era_idx   = c_side_out.era_idx;
        g_side_next.doe       = c_side_out.doe;
        g_side_next.weekday   = weekday_of(c_side_out.doe);
        g_side_next.tod       = c_side_out.tod;
        g_side_next.range_err = c_side_out.range_err;
    end

    assign g_rdy = !g_v_reg || d_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_v_reg <= 1'b0;
        end else if (g_rdy) begin
            g_v_reg <= c_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (g_rdy && c_out_valid) begin
            g_num_reg  <= g_num_next;
            g_side_reg <= g_side_next;
        end
    end

    // year of era
    d_side_t          d_side_out;
    logic             d_out_valid, cal_in_ready;
    logic [YOE_W-1:0] d_quot;

    ecd_cdiv #(
        .DIVISOR (YEAR_DAYS),
        .QW      (YOE_W),
        .SW      ($bits(d_side_t)),
        .STEPS   (DIV_STEPS)
    ) u_div_yoe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (g_v_reg),
        .in_ready    (d_in_ready),
        .in_dividend (g_num_reg),
        .in_side     (g_side_reg),
        .out_valid   (d_out_valid),
        .out_ready   (cal_in_ready),
        .out_quot    (d_quot),
        .out_rem     (),
        .out_side    (d_side_out)
    );

    cal_t cal_out;
    logic cal_out_valid, e_in_ready;

    ecd_cal u_cal (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_out_valid),
        .in_ready  (cal_in_ready),
        .in_yoe    (d_quot),
        .in_side   (d_side_out),
        .out_valid (cal_out_valid),
        .out_ready (e_in_ready),
        .out_cal   (cal_out)
    );

    // time of day: hours, minutes, seconds
    date_t             e_side_out;
    logic              e_out_valid, f2_in_ready;
    logic [HOUR_W-1:0] e_quot;
    logic [21:0]       e_rem;

    ecd_cdiv #(
        .DIVISOR (MS_PER_HOUR),
        .QW      (HOUR_W),
        .SW      ($bits(date_t)),
        .STEPS   (DIV_STEPS)
    ) u_div_hour (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (cal_out_valid),
        .in_ready    (e_in_ready),
        .in_dividend (cal_out.tod),
        .in_side     (cal_out.date),
        .out_valid   (e_out_valid),
        .out_ready   (f2_in_ready),
        .out_quot    (e_quot),
        .out_rem     (e_rem),
        .out_side    (e_side_out)
    );

    hr_side_t          hr_side_in, hr_side_out;
    logic              hr_out_valid, mn_in_ready;
    logic [MIN_W-1:0]  hr_quot;
    logic [15:0]       hr_rem;

    assign hr_side_in.hour = e_quot;
    assign hr_side_in.date = e_side_out;

    ecd_cdiv #(
        .DIVISOR (MS_PER_MIN),
        .QW      (MIN_W),
        .SW      ($bits(hr_side_t)),
        .STEPS   (DIV_STEPS)
    ) u_div_min (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (e_out_valid),
        .in_ready    (f2_in_ready),
        .in_dividend (e_rem),
        .in_side     (hr_side_in),
        .out_valid   (hr_out_valid),
        .out_ready   (mn_in_ready),
        .out_quot    (hr_quot),
        .out_rem     (hr_rem),
        .out_side    (hr_side_out)
    );

    min_side_t         mn_side_in, mn_side_out;
    logic [SEC_W-1:0]  mn_quot;
    logic [MSEC_W-1:0] mn_rem;

    assign mn_side_in.minute = hr_quot;
    assign mn_side_in.hour   = hr_side_out.hour;
    assign mn_side_in.date   = hr_side_out.date;

    ecd_cdiv #(
        .DIVISOR (MS_PER_SEC),
        .QW      (SEC_W),
        .SW      ($bits(min_side_t)),
        .STEPS   (DIV_STEPS)
    ) u_div_sec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (hr_out_valid),
        .in_ready    (mn_in_ready),
        .in_dividend (hr_rem),
        .in_side     (mn_side_in),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_quot    (mn_quot),
        .out_rem     (mn_rem),
        .out_side    (mn_side_out)
    );

    assign m_year        = $signed(mn_side_out.date.year);
    assign m_month       = mn_side_out.date.month;
    assign m_day         = mn_side_out.date.day;
    assign m_hour        = mn_side_out.hour;
    assign m_minute      = mn_side_out.minute;
    assign m_second      = mn_quot;
    assign m_millisecond = mn_rem;
    assign m_weekday     = mn_side_out.date.weekday;
    assign m_day_of_year = mn_side_out.date.yday;
    assign m_range_error = mn_side_out.date.range_err;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for epoch_ms_to_civil_date_time: directed corners, then random stamps.
// Predicts each date/time word in a scoreboard class; uses widths from ecd_pkg.
`timescale 1ns / 1ps

module tb_top;
    import ecd_pkg::*;

    localparam longint EPOCH_LIMIT = 64'sd8640000000000000;
    localparam longint MS_DAY      = 64'sd86400000;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MON_W-1:0]         month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MIN_W-1:0]         minute;
        logic [SEC_W-1:0]         second;
        logic [MSEC_W-1:0]        millisecond;
        logic [WDAY_W-1:0]        weekday;
        logic [YDAY_W-1:0]        day_of_year;
        logic                     range_error;
    } civil_t;

    class date_scoreboard;
        civil_t pending_dates[$];
        int     mismatches = 0;
        int     jan_offset[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

        function civil_t civil_from_ms(logic signed [MS_W-1:0] stamp);
            civil_t r;
            longint ms, days, tod, z, era, doe, yoe, doy, mp, dom, mon, yr, wd, yd;
            bit     leap;
            r = '0;
            ms = stamp;
            if (ms < -EPOCH_LIMIT || ms > EPOCH_LIMIT) begin
                r.range_error = 1'b1;
                return r;
            end
            days = ms / MS_DAY;
            tod  = ms % MS_DAY;
            if (tod < 0) begin
                tod  = tod + MS_DAY;
                days = days - 1;
            end
            z   = days + 719468;
            era = (z >= 0 ? z : z - 146096) / 146097;
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100 + yoe / 400);
            mp  = (5 * doy + 2) / 153;
            dom = doy - (153 * mp + 2) / 5 + 1;
            mon = mp < 10 ? mp + 3 : mp - 9;
            yr  = yoe + era * 400 + (mon <= 2 ? 1 : 0);
            wd  = (days + 4) % 7;
            if (wd < 0) begin
                wd = wd + 7;
            end
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            yd = jan_offset[mon - 1] + dom + ((leap && mon > 2) ? 1 : 0);
            r.year        = yr[YEAR_W-1:0];
            r.month       = mon[MON_W-1:0];
            r.day         = dom[DAY_W-1:0];
            r.hour        = 5'(tod / 3600000);
            r.minute      = 6'((tod % 3600000) / 60000);
            r.second      = 6'((tod % 60000) / 1000);
            r.millisecond = 10'(tod % 1000);
            r.weekday     = wd[WDAY_W-1:0];
            r.day_of_year = yd[YDAY_W-1:0];
            return r;
        endfunction

        function void note_epoch(logic signed [MS_W-1:0] stamp);
            pending_dates.insert(pending_dates.size(), civil_from_ms(stamp));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_date(civil_t got);
            civil_t want;
            if (pending_dates.size() == 0) begin
                $display("%0t unexpected word: year %0d month %0d day %0d",
                         $time, got.year, got.month, got.day);
                mismatches++;
                return;
            end
            want = pending_dates.pop_front();
            compare_field("year", want.year, got.year);
            compare_field("month", want.month, got.month);
            compare_field("day", want.day, got.day);
            compare_field("hour", want.hour, got.hour);
            compare_field("minute", want.minute, got.minute);
            compare_field("second", want.second, got.second);
            compare_field("millisecond", want.millisecond, got.millisecond);
            compare_field("weekday", want.weekday, got.weekday);
            compare_field("day_of_year", want.day_of_year, got.day_of_year);
            compare_field("range_error", want.range_error, got.range_error);
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [MS_W-1:0]   s_epoch_ms = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [YEAR_W-1:0] m_year;
    logic [MON_W-1:0]         m_month;
    logic [DAY_W-1:0]         m_day;
    logic [HOUR_W-1:0]        m_hour;
    logic [MIN_W-1:0]         m_minute;
    logic [SEC_W-1:0]         m_second;
    logic [MSEC_W-1:0]        m_millisecond;
    logic [WDAY_W-1:0]        m_weekday;
    logic [YDAY_W-1:0]        m_day_of_year;
    logic                     m_range_error;

    date_scoreboard sb = new();
    bit             no_idle = 1'b0;
    civil_t         got_word;

    always #1 aclk = ~aclk;

    epoch_ms_to_civil_date_time dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_epoch_ms    (s_epoch_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_year        (m_year),
        .m_month       (m_month),
        .m_day         (m_day),
        .m_hour        (m_hour),
        .m_minute      (m_minute),
        .m_second      (m_second),
        .m_millisecond (m_millisecond),
        .m_weekday     (m_weekday),
        .m_day_of_year (m_day_of_year),
        .m_range_error (m_range_error)
    );

    task automatic push_epoch(input logic signed [MS_W-1:0] stamp);
        s_epoch_ms <= stamp;
        s_valid    <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_epoch(stamp);
        while (!no_idle && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got_word.year        = m_year;
                got_word.month       = m_month;
                got_word.day         = m_day;
                got_word.hour        = m_hour;
                got_word.minute      = m_minute;
                got_word.second      = m_second;
                got_word.millisecond = m_millisecond;
                got_word.weekday     = m_weekday;
                got_word.day_of_year = m_day_of_year;
                got_word.range_error = m_range_error;
                sb.check_date(got_word);
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    initial begin
        longint corner_ms[] = '{
            0, -1, 1, 86399999, 86400000, -86400000, -86400001,
            EPOCH_LIMIT, -EPOCH_LIMIT, EPOCH_LIMIT + 1, -EPOCH_LIMIT - 1,
            64'sd9007199254740991, -64'sd9007199254740992,
            11016 * MS_DAY, 11017 * MS_DAY - 1, 11017 * MS_DAY,
            -25509 * MS_DAY, -25508 * MS_DAY - 1, -25508 * MS_DAY,
            -719468 * MS_DAY, -719468 * MS_DAY - 1,
            20089 * MS_DAY - 1, 20089 * MS_DAY,
            64'sd1000000000000000, -64'sd4503599627370496
        };
        bit [63:0] r;
        longint    v;
        longint    days;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_ms[i]) begin
            push_epoch(corner_ms[i][MS_W-1:0]);
        end

        for (int n = 0; n < 550; n++) begin
            no_idle = (n >= 200 && n < 320);
            r = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0, 1: v = $signed(r[MS_W-1:0]);
                2, 3, 4: v = longint'(r % 64'd17280000000000001) - EPOCH_LIMIT;
                5, 6: v = $signed(r[43:0]);
                7, 8: begin
                    days = longint'(r % 64'd200000001) - 100000000;
                    v = days * MS_DAY + longint'($urandom_range(0, 2)) - 1;
                end
                default: v = ($urandom_range(0, 1) ? EPOCH_LIMIT : -EPOCH_LIMIT)
                             + longint'($urandom_range(0, 6)) - 3;
            endcase
            push_epoch(v[MS_W-1:0]);
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending_dates.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("[epoch_ms_to_civil_date_time] OK");
        end else begin
            $display("[epoch_ms_to_civil_date_time] ERROR");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("[epoch_ms_to_civil_date_time] ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/ecd_pkg.sv
sv/ecd_cdiv.sv
sv/ecd_cal.sv
sv/epoch_ms_to_civil_date_time.sv
tb/sv/tb_top.sv
